// ===== sv/fat_entry_scan_checker_unit_assert.svh =====
// assertion macros shared by the scan checker rtl
`ifndef FAT_ENTRY_SCAN_CHECKER_UNIT_ASSERT_SVH
`define FAT_ENTRY_SCAN_CHECKER_UNIT_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define FESC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define FESC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/fesc_pkg.sv =====
// types, codes and helpers of the fat entry scan checker
package fesc_pkg;

  // entry classes as reported on entry_class
  typedef enum logic [2:0] {
    CLS_FREE     = 3'd0,
    CLS_BAD      = 3'd1,
    CLS_EOC      = 3'd2,
    CLS_LINK     = 3'd3,
    CLS_DUP      = 3'd4,
    CLS_INVALID  = 3'd5,
    CLS_READ_ERR = 3'd6
  } cls_t;

  // fat32 entry encodings, low 28 bits only
  localparam int unsigned ENTRY_W = 28;
  localparam logic [ENTRY_W-1:0] ENTRY_FREE    = 28'h0000000;
  localparam logic [ENTRY_W-1:0] ENTRY_BAD     = 28'hFFFFFF7;
  localparam logic [ENTRY_W-1:0] ENTRY_EOC_MIN = 28'hFFFFFF8;
  localparam logic [ENTRY_W-1:0] FIRST_CLUSTER = 28'h0000002;

  // counters and configuration
  localparam int unsigned CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;
  localparam logic [CNT_W-1:0] CLUSTER_TOTAL_RST = 16'd65534;

  // apb register map
  localparam int unsigned PADDR_W = 2;
  localparam logic [PADDR_W-1:0] ADDR_CLUSTER_TOTAL = 2'd0;

  // scan epoch tag stored per map entry; tag zero means never seen
  localparam int unsigned EPOCH_W = 4;
  typedef logic [EPOCH_W-1:0] tag_t;
  localparam tag_t EPOCH_NONE  = 4'd0;
  localparam tag_t EPOCH_FIRST = 4'd1;
  localparam tag_t EPOCH_LAST  = 4'd15;

  // write side of the seen map
  typedef struct packed {
    logic en;
    tag_t tag;
  } seen_wr_t;

  // saturating increment
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? CNT_MAX : v + 16'd1;
  endfunction

endpackage

// ===== sv/fesc_apb_regs.sv =====
// apb register block holding the cluster count
module fesc_apb_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fesc_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [fesc_pkg::CNT_W-1:0]    cluster_total
);

  logic wr_hit;

  // write strobe on the access phase
  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && pready
                  && (paddr == fesc_pkg::ADDR_CLUSTER_TOTAL);

  // cluster count register
  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_total <= fesc_pkg::CLUSTER_TOTAL_RST;
    end else if (wr_hit) begin
      cluster_total <= pwdata[fesc_pkg::CNT_W-1:0];
    end
  end

  // read mux
  always_comb begin
    if (paddr == fesc_pkg::ADDR_CLUSTER_TOTAL) begin
      prdata = {16'd0, cluster_total};
    end else begin
      prdata = 32'd0;
    end
  end

endmodule

// ===== sv/fesc_seen_mem.sv =====
// seen map: one epoch tag per cluster, with its clearing sweep
module fesc_seen_mem #(
  parameter int unsigned MAP_DEPTH = 65536
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [$clog2(MAP_DEPTH)-1:0] rd_addr,
  output fesc_pkg::tag_t            rd_tag,
  input  fesc_pkg::seen_wr_t        wr,
  input  logic [$clog2(MAP_DEPTH)-1:0] wr_addr,
  input  logic                      clear_start,
  output logic                      clearing
);

  localparam int unsigned AW = $clog2(MAP_DEPTH);
  localparam logic [AW-1:0] ADDR_LAST = AW'(MAP_DEPTH - 1);

  fesc_pkg::tag_t mem [MAP_DEPTH];
  logic [AW-1:0]  clr_addr;

  // clearing sweep, one entry a cycle, after reset and on request
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_LAST) begin
        clearing <= 1'b0;
      end
    end else if (clear_start) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end
  end

  // single write port
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= fesc_pkg::EPOCH_NONE;
    end else if (wr.en) begin
      mem[wr_addr] <= wr.tag;
    end
  end

  // registered read port, read before write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_tag <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/fat_entry_scan_checker_unit.sv =====
// top level: fat entry classification with seen-map duplicate check
// an accepted word passes stage 1 (map read) and then the output register before its result is offered
// throughput: one word per cycle while in_stall is low (output not blocked, no map sweep, no epoch wrap)
// a link to the cluster written by the word just ahead is caught by forwarding
// reset: counters zero, cluster_total 65534, then a clearing sweep of all MAP_DEPTH map entries
// the same sweep runs after every 15th scan when the 4-bit epoch tag wraps
module fat_entry_scan_checker_unit #(
  parameter int unsigned MAP_DEPTH = 65536  // power of two
) (
  input  logic                            clk,
  input  logic                            rst,
  // apb configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fesc_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // entry words in
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [31:0]                     entry_value,
  input  logic                            read_failed,
  input  logic                            final_entry,
  // results out
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      entry_class,
  output logic [fesc_pkg::CNT_W-1:0]      free_total,
  output logic [fesc_pkg::CNT_W-1:0]      bad_total,
  output logic [fesc_pkg::CNT_W-1:0]      error_total,
  output logic                            scan_corrupt,
  output logic                            scan_done
);

  `include "fat_entry_scan_checker_unit_assert.svh"

  localparam int unsigned AW = $clog2(MAP_DEPTH);

  logic [fesc_pkg::CNT_W-1:0]   cluster_total;
  logic [fesc_pkg::ENTRY_W-1:0] val;
  logic [fesc_pkg::CNT_W:0]     link_max;
  fesc_pkg::cls_t               in_kind;
  logic                         advance, wrap_hold, accept, clearing, clear_start;
  logic [AW-1:0]                in_addr;

  // stage 1: map read in flight
  logic                         s1_valid;
  fesc_pkg::cls_t               s1_kind;
  logic [AW-1:0]                s1_addr;
  logic                         s1_final;
  logic                         s1_fwd;
  fesc_pkg::tag_t               rd_tag;
  fesc_pkg::tag_t               epoch;
  fesc_pkg::seen_wr_t           seen_wr;
  fesc_pkg::cls_t               s1_cls;
  logic                         s1_seen;
  logic                         scan_end;

  // running counters
  logic [fesc_pkg::CNT_W-1:0]   free_cnt, bad_cnt, err_cnt;
  logic [fesc_pkg::CNT_W-1:0]   free_cnt_next, bad_cnt_next, err_cnt_next;

  fesc_apb_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .cluster_total (cluster_total)
  );

  // handshake: hold input while the output is blocked, the map is swept,
  // or a final word that wraps the epoch is still ahead
  assign advance   = !out_valid || !out_stall;
  assign wrap_hold = s1_valid && s1_final && (epoch == fesc_pkg::EPOCH_LAST);
  assign in_stall  = !advance || clearing || wrap_hold;
  assign accept    = in_valid && !in_stall;

  // stage 0 classification, seen check deferred
  assign val      = entry_value[fesc_pkg::ENTRY_W-1:0];
  assign link_max = {1'b0, cluster_total} + 17'd1;
  assign in_addr  = val[AW-1:0];

  always_comb begin
    priority if (read_failed) begin
      in_kind = fesc_pkg::CLS_READ_ERR;
    end else if (val == fesc_pkg::ENTRY_FREE) begin
      in_kind = fesc_pkg::CLS_FREE;
    end else if (val == fesc_pkg::ENTRY_BAD) begin
      in_kind = fesc_pkg::CLS_BAD;
    end else if (val >= fesc_pkg::ENTRY_EOC_MIN) begin
      in_kind = fesc_pkg::CLS_EOC;
    end else if (val >= fesc_pkg::FIRST_CLUSTER
                 && val <= {11'd0, link_max}) begin
      in_kind = fesc_pkg::CLS_LINK;
    end else begin
      in_kind = fesc_pkg::CLS_INVALID;
    end
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
    end
  end

  // stage 1 payload; forward a same-scan link write from the word ahead
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind  <= in_kind;
      s1_addr  <= in_addr;
      s1_final <= final_entry;
      s1_fwd   <= s1_valid && (s1_kind == fesc_pkg::CLS_LINK) && !s1_final
                  && (s1_addr == in_addr);
    end
  end

  // seen map and its write-back
  assign seen_wr.en   = s1_valid && advance && (s1_kind == fesc_pkg::CLS_LINK);
  assign seen_wr.tag  = epoch;
  assign clear_start  = s1_valid && advance && wrap_hold;
  assign scan_end     = s1_valid && advance && s1_final;

  fesc_seen_mem #(
    .MAP_DEPTH (MAP_DEPTH)
  ) u_seen (
    .clk         (clk),
    .rst         (rst),
    .rd_en       (accept),
    .rd_addr     (in_addr),
    .rd_tag      (rd_tag),
    .wr          (seen_wr),
    .wr_addr     (s1_addr),
    .clear_start (clear_start),
    .clearing    (clearing)
  );

  // scan epoch, stepped at each scan end
  always_ff @(posedge clk) begin
    if (rst) begin
      epoch <= fesc_pkg::EPOCH_FIRST;
    end else if (s1_valid && advance && s1_final) begin
      epoch <= (epoch == fesc_pkg::EPOCH_LAST) ? fesc_pkg::EPOCH_FIRST : epoch + 1'b1;
    end
  end

  // final class and counter updates
  assign s1_seen = s1_fwd || (rd_tag == epoch);

  always_comb begin
    s1_cls = s1_kind;
    if (s1_kind == fesc_pkg::CLS_LINK && s1_seen) begin
      s1_cls = fesc_pkg::CLS_DUP;
    end
    free_cnt_next = free_cnt;
    bad_cnt_next  = bad_cnt;
    err_cnt_next  = err_cnt;
    unique case (s1_cls)
      fesc_pkg::CLS_FREE:     free_cnt_next = fesc_pkg::sat_inc(free_cnt);
      fesc_pkg::CLS_BAD:      bad_cnt_next  = fesc_pkg::sat_inc(bad_cnt);
      fesc_pkg::CLS_DUP,
      fesc_pkg::CLS_INVALID,
      fesc_pkg::CLS_READ_ERR: err_cnt_next  = fesc_pkg::sat_inc(err_cnt);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_cnt <= '0;
      bad_cnt  <= '0;
      err_cnt  <= '0;
    end else if (s1_valid && advance) begin
      if (s1_final) begin
        free_cnt <= '0;
        bad_cnt  <= '0;
        err_cnt  <= '0;
      end else begin
        free_cnt <= free_cnt_next;
        bad_cnt  <= bad_cnt_next;
        err_cnt  <= err_cnt_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      entry_class  <= 3'(s1_cls);
      free_total   <= free_cnt_next;
      bad_total    <= bad_cnt_next;
      error_total  <= err_cnt_next;
      scan_corrupt <= (err_cnt_next != '0);
      scan_done    <= s1_final;
    end
  end

  // checks
  `FESC_ASSERT_NOW(a_no_accept_in_sweep, clearing, !accept, "word accepted during map sweep")
  `FESC_ASSERT_NEXT(a_wrap_starts_sweep, clear_start, clearing, "epoch wrap without sweep")
  `FESC_ASSERT_NEXT(a_counts_clr, scan_end, (free_cnt | bad_cnt | err_cnt) == '0, "counts kept")
  `FESC_ASSERT_NOW(a_corrupt, out_valid, scan_corrupt == (error_total != '0), "corrupt flag")

endmodule
